// File: rtl/core/phase_sync_collinearity_check_macros.svh
// Assertion macros shared by the phase-sync collinearity check RTL
`ifndef PHASE_SYNC_COLLINEARITY_CHECK_MACROS_SVH
`define PHASE_SYNC_COLLINEARITY_CHECK_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PSCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pscc_pkg.sv
// Types and constants of the phase-sync collinearity check
package pscc_pkg;

    localparam int unsigned EPS_W = 31;
    localparam logic [EPS_W-1:0] EPS_RESET = 31'd1074;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic               axis_selected;
        logic signed [31:0] current_velocity;
        logic signed [31:0] target_velocity;
        logic               last_axis;
    } pscc_in_t;

    typedef struct packed {
        logic signed [31:0] norm_current;
        logic signed [31:0] norm_target;
        logic signed [31:0] reference_component;
        logic               sync_possible;
        logic               last_result;
    } pscc_out_t;

endpackage

// File: rtl/core/phase_sync_collinearity_check.sv
// A request without last_axis holds the input through its accept, square and sum steps.
// A last_axis request adds a bit-serial square root of each sum, then bit-serial division
// of both components per axis, then sign and check passes if the reference clears epsilon.
// Results leave the output register one per cycle unless out_stall holds them. The next
// request waits for the final result. Reset clears control, sums, count; epsilon is 1074.
module phase_sync_collinearity_check #(
    parameter int MAX_AXES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  pscc_pkg::pscc_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pscc_pkg::pscc_out_t out_data
);
    import pscc_pkg::*;
    `include "phase_sync_collinearity_check_macros.svh"

    localparam int CNT_W = $clog2(MAX_AXES + 1);
    localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam logic REG_EPSILON = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_ROOT, S_ROOT_WAIT,
        S_DIV, S_DIV_WAIT, S_SIGN, S_CHECK, S_EMIT
    } state_t;

    function automatic logic [32:0] abs33(input logic [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               phase_reg;
    logic               stored_reg;
    logic               last_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic [31:0]        mag_c_reg, mag_t_reg;
    logic [63:0]        prod_c_reg, prod_t_reg;
    logic [63:0]        sum_c_reg, sum_t_reg;
    logic [31:0]        lc_reg, lt_reg;
    logic               keep_c_reg, keep_t_reg, ok_reg;
    logic               out_valid_reg;
    pscc_out_t          out_data_reg;

    logic signed [31:0] cur_mem [MAX_AXES];
    logic signed [31:0] tgt_mem [MAX_AXES];
    logic               sel_mem [MAX_AXES];
    logic signed [31:0] nc_mem  [MAX_AXES];
    logic signed [31:0] nt_mem  [MAX_AXES];

    logic               in_acc, out_free, cfg_wr, room, at_last;
    logic [IDX_W-1:0]   widx, ridx;
    logic [31:0]        in_mag_c, in_mag_t;
    logic [64:0]        add_c, add_t;
    logic               root_start, root_done, div_start, div_done;
    logic [31:0]        root_val, div_num, div_len;
    logic [30:0]        div_q;
    logic [31:0]        cur_v, tgt_v, div_v, norm_val;
    logic               sel_i, t_ref, ok0;
    logic [31:0]        lref;
    logic [31:0]        nc_i, nt_i, rf_i, ncf, ntf;
    logic [32:0]        eps_x;
    logic               hit_c, hit_t, mism_c, mism_t;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_EPSILON);
    assign prdata   = (paddr[2] == REG_EPSILON) ? {1'b0, eps_reg} : 32'd0;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign room    = count_reg < CNT_W'(MAX_AXES);
    assign widx    = count_reg[IDX_W-1:0];
    assign ridx    = idx_reg[IDX_W-1:0];
    assign at_last = idx_reg == (count_reg - CNT_W'(1));

    assign in_mag_c = in_data.current_velocity[31] ? 32'(-in_data.current_velocity)
                                                   : in_data.current_velocity;
    assign in_mag_t = in_data.target_velocity[31] ? 32'(-in_data.target_velocity)
                                                  : in_data.target_velocity;
    // saturate at all ones on carry out
    assign add_c = {1'b0, sum_c_reg} + {1'b0, prod_c_reg};
    assign add_t = {1'b0, sum_t_reg} + {1'b0, prod_t_reg};

    assign root_start = (state_reg == S_ROOT);
    assign div_start  = (state_reg == S_DIV);

    pscc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (phase_reg ? sum_t_reg : sum_c_reg),
        .done     (root_done),
        .root     (root_val)
    );

    assign cur_v   = cur_mem[ridx];
    assign tgt_v   = tgt_mem[ridx];
    assign sel_i   = sel_mem[ridx];
    assign div_v   = phase_reg ? tgt_v : cur_v;
    assign div_num = div_v[31] ? 32'(-div_v) : div_v;
    assign div_len = phase_reg ? lt_reg : lc_reg;

    pscc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_num),
        .divisor  (div_len),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (!sel_i || div_len == 32'd0)
            norm_val = 32'd0;
        else if (div_v[31])
            norm_val = 32'(-{1'b0, div_q});
        else
            norm_val = {1'b0, div_q};
    end

    assign t_ref = lt_reg >= lc_reg;
    assign lref  = t_ref ? lt_reg : lc_reg;
    assign ok0   = {lref, 14'd0} > {15'd0, eps_reg};
    assign eps_x = {2'b00, eps_reg};

    assign nc_i = nc_mem[ridx];
    assign nt_i = nt_mem[ridx];
    assign rf_i = t_ref ? nt_i : nc_i;
    assign ncf  = keep_c_reg ? nc_i : 32'(-nc_i);
    assign ntf  = keep_t_reg ? nt_i : 32'(-nt_i);

    assign hit_c = sel_i && (nc_i[31] == rf_i[31]) && (abs33({nc_i[31], nc_i}) > eps_x);
    assign hit_t = sel_i && (nt_i[31] == rf_i[31]) && (abs33({nt_i[31], nt_i}) > eps_x);
    assign mism_c = (abs33({rf_i[31], rf_i} - {ncf[31], ncf}) > eps_x)
                    && (abs33({ncf[31], ncf}) > eps_x);
    assign mism_t = (abs33({rf_i[31], rf_i} - {ntf[31], ntf}) > eps_x)
                    && (abs33({ntf[31], ntf}) > eps_x);

    // axis and normalized component stores
    always_ff @(posedge clk)
    begin
        if (in_acc && room)
        begin
            cur_mem[widx] <= in_data.current_velocity;
            tgt_mem[widx] <= in_data.target_velocity;
            sel_mem[widx] <= in_data.axis_selected;
        end
        if (state_reg == S_DIV_WAIT && div_done)
        begin
            if (phase_reg)
                nt_mem[ridx] <= norm_val;
            else
                nc_mem[ridx] <= norm_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            stored_reg    <= 1'b0;
            last_reg      <= 1'b0;
            eps_reg       <= EPS_RESET;
            mag_c_reg     <= '0;
            mag_t_reg     <= '0;
            prod_c_reg    <= '0;
            prod_t_reg    <= '0;
            sum_c_reg     <= '0;
            sum_t_reg     <= '0;
            lc_reg        <= '0;
            lt_reg        <= '0;
            keep_c_reg    <= 1'b1;
            keep_t_reg    <= 1'b1;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_wr)
                eps_reg <= pwdata[EPS_W-1:0];
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        stored_reg <= room && in_data.axis_selected;
                        last_reg   <= in_data.last_axis;
                        mag_c_reg  <= in_mag_c;
                        mag_t_reg  <= in_mag_t;
                        if (room)
                            count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_c_reg <= mag_c_reg * mag_c_reg;
                    prod_t_reg <= mag_t_reg * mag_t_reg;
                    state_reg  <= S_ACC;
                end
                S_ACC:
                begin
                    if (stored_reg)
                    begin
                        sum_c_reg <= add_c[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add_c[63:0];
                        sum_t_reg <= add_t[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add_t[63:0];
                    end
                    phase_reg <= 1'b0;
                    state_reg <= last_reg ? S_ROOT : S_IDLE;
                end
                S_ROOT:
                begin
                    state_reg <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT:
                begin
                    if (root_done)
                    begin
                        if (phase_reg)
                        begin
                            lt_reg    <= root_val;
                            phase_reg <= 1'b0;
                            idx_reg   <= '0;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            lc_reg    <= root_val;
                            phase_reg <= 1'b1;
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        phase_reg <= !phase_reg;
                        state_reg <= S_DIV;
                        if (phase_reg)
                        begin
                            if (at_last)
                            begin
                                idx_reg    <= '0;
                                ok_reg     <= ok0;
                                keep_c_reg <= !ok0;
                                keep_t_reg <= !ok0;
                                state_reg  <= ok0 ? S_SIGN : S_EMIT;
                            end
                            else
                                idx_reg <= idx_reg + CNT_W'(1);
                        end
                    end
                end
                S_SIGN:
                begin
                    // keep orientation once a significant component agrees in sign
                    keep_c_reg <= keep_c_reg | hit_c;
                    keep_t_reg <= keep_t_reg | hit_t;
                    if (at_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CHECK;
                    end
                    else
                        idx_reg <= idx_reg + CNT_W'(1);
                end
                S_CHECK:
                begin
                    if (sel_i && (mism_c || mism_t))
                        ok_reg <= 1'b0;
                    if (at_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                        idx_reg <= idx_reg + CNT_W'(1);
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                    <= 1'b1;
                        out_data_reg.norm_current        <= ncf;
                        out_data_reg.norm_target         <= ntf;
                        out_data_reg.reference_component <= ok_reg ? rf_i : 32'sd0;
                        out_data_reg.sync_possible       <= ok_reg;
                        out_data_reg.last_result         <= at_last;
                        if (at_last)
                        begin
                            idx_reg   <= '0;
                            count_reg <= '0;
                            sum_c_reg <= '0;
                            sum_t_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                            idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PSCC_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall,
        "request not held off")
    `PSCC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_AXES),
        "axis count overflow")
    `PSCC_ASSERT_NOW(a_ref_zero_on_fail, out_valid && !out_data.sync_possible,
        out_data.reference_component == 32'sd0, "reference not cleared")

endmodule

// File: rtl/core/pscc_sqrt.sv
// Floor square root of a 64-bit value, two radicand bits per cycle
module pscc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import pscc_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg;
    logic [34:0] rem_t;
    logic [34:0] trial;
    logic        fits;

    assign rem_t = {rem_reg, rad_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fits  = rem_t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? 33'(rem_t - trial) : rem_t[32:0];
                root_reg <= {root_reg[30:0], fits};
                rad_reg  <= {rad_reg[61:0], 2'b00};
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/pscc_div.sv
// Restoring divider, one quotient bit per cycle, for (mag << 30) / len capped at 1.0 in Q1.30
module pscc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] numer,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [30:0] quotient
);
    import pscc_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [5:0]  cnt_reg;
    logic [61:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [30:0] q_reg;
    logic [32:0] rem_t;
    logic [32:0] diff;
    logic        fits;

    assign rem_t = {rem_reg, dvd_reg[61]};
    assign diff  = rem_t - {1'b0, divisor};
    assign fits  = rem_t >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ovf_reg  <= 1'b0;
                cnt_reg  <= 6'd61;
                dvd_reg  <= {numer[31:0], 30'd0};
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[31:0] : rem_t[31:0];
                q_reg   <= {q_reg[29:0], fits};
                ovf_reg <= ovf_reg | q_reg[30];
                dvd_reg <= {dvd_reg[60:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = (ovf_reg || q_reg > ONE_Q30) ? ONE_Q30 : q_reg;

endmodule
